### rtl/iap_pkg.sv
// ----------------------------------------------------------------------------
// iap_pkg
// Shared constants, codes and types of the isochronous audio packet pacer.
// ----------------------------------------------------------------------------
package iap_pkg;

   // field widths
   localparam int unsigned RATE_W     = 20;
   localparam int unsigned FRAME_W    = 10;
   localparam int unsigned MPS_W      = 9;
   localparam int unsigned RING_W     = 23;
   localparam int unsigned BYTES_W    = 9;
   localparam int unsigned COUNT_W    = 32;

   localparam int unsigned MAX_PACKET_BYTES = 256;
   localparam int unsigned RING_BYTES_MAX   = 4194304;
   localparam int unsigned MS_PER_SECOND    = 1000;

   // 21-bit accumulator (remainder plus 20-bit rate) / 1000 gives at most 11 quotient bits
   localparam int unsigned ACC_W   = 21;
   localparam int unsigned QUO_W   = 11;
   localparam int unsigned REM_W   = 10;
   localparam int unsigned PROD_W  = QUO_W + FRAME_W;

   // ceil(2^29 / 1000): floor(acc * RECIP_MUL / 2^29) == acc / 1000 for any 21-bit acc
   localparam int unsigned RECIP_W      = 20;
   localparam int unsigned RECIP_SHIFT  = 29;
   localparam int unsigned RECIP_MUL    = 536871;
   localparam int unsigned RECIP_PROD_W = ACC_W + RECIP_W;

   // shift-subtract unit for the frame rounding
   localparam int unsigned STEP_W  = 4;
   localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(BYTES_W);

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = RATE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_IN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PACKET   = 2'd3;

   // command codes
   localparam logic CMD_PREPARE  = 1'b0;
   localparam logic CMD_COMPLETE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_CLAMP,
      ST_TAKE,
      ST_MOD,
      ST_TRIM,
      ST_UPD,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic recip;
      logic step;
      logic mul;
      logic clamp;
      logic take;
      logic trim;
      logic upd;
      logic out_load;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic route_paced;
      logic route_play;
      logic frame_nz;
      logic step_last;
      logic out_free;
   } status_type;

endpackage

### rtl/iap_req_if.sv
// ----------------------------------------------------------------------------
// iap_req_if
// Command channel of the packet pacer: valid/ready with the command payload.
// ----------------------------------------------------------------------------
interface iap_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [iap_pkg::RING_W-1:0]     ring_level;
   logic [iap_pkg::RING_W-1:0]     ring_room;
   logic                           packet_ok;
   logic [iap_pkg::BYTES_W-1:0]    packet_actual;

   modport source (output valid, command, ring_level, ring_room, packet_ok, packet_actual,
                   input ready);
   modport sink   (input valid, command, ring_level, ring_room, packet_ok, packet_actual,
                   output ready);
endinterface

### rtl/iap_rsp_if.sv
// ----------------------------------------------------------------------------
// iap_rsp_if
// Result channel of the packet pacer: valid/ready with packet sizes and counters.
// ----------------------------------------------------------------------------
interface iap_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [iap_pkg::BYTES_W-1:0]    packet_bytes;
   logic [iap_pkg::BYTES_W-1:0]    pop_bytes;
   logic [iap_pkg::BYTES_W-1:0]    silence_bytes;
   logic [iap_pkg::BYTES_W-1:0]    push_bytes;
   logic [iap_pkg::COUNT_W-1:0]    packet_count;
   logic [iap_pkg::COUNT_W-1:0]    byte_count;
   logic [iap_pkg::COUNT_W-1:0]    dropped_count;
   logic [iap_pkg::COUNT_W-1:0]    starved_count;
   logic [iap_pkg::COUNT_W-1:0]    error_count;
   logic [iap_pkg::COUNT_W-1:0]    empty_count;

   modport source (output valid, packet_bytes, pop_bytes, silence_bytes, push_bytes,
                   packet_count, byte_count, dropped_count, starved_count, error_count,
                   empty_count, input ready);
   modport sink   (input valid, packet_bytes, pop_bytes, silence_bytes, push_bytes,
                   packet_count, byte_count, dropped_count, starved_count, error_count,
                   empty_count, output ready);
endinterface

### rtl/iso_audio_packet_pacer.sv
// ----------------------------------------------------------------------------
// iso_audio_packet_pacer
// Sizes isochronous audio packets per 1 ms interval and keeps the packet
// statistics for completed transfers.
//
//   channel   dir   handshake        carries
//   req_if    in    valid/ready      command, ring_level, ring_room, packet_ok,
//                                    packet_actual
//   rsp_if    out   valid/ready      packet/pop/silence/push bytes, six counters
//   csr_*     in    write enable     register index, write data
//
// One command at a time. A paced playback prepare takes one reciprocal
// multiply for the divide by 1000 and 9 steps of the frame rounding; an
// unpaced playback prepare takes only the rounding, or skips it when
// frame_bytes is zero; capture prepare and complete go straight to the
// counter update. The next command is taken the cycle after the result
// enters the output register, which holds it while rsp_if.ready is low.
// Reset is synchronous: config to defaults, rate remainder and counters cleared.
// ----------------------------------------------------------------------------
module iso_audio_packet_pacer (
   input  logic                              clock,
   input  logic                              reset,
   iap_req_if.sink                           req_if,
   iap_rsp_if.source                         rsp_if,
   input  logic                              csr_write_en,
   input  logic [iap_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iap_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   iap_pkg::ctrl_type   ctrl;
   iap_pkg::status_type stat;

   iap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   iap_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_command       (req_if.command),
      .req_ring_level    (req_if.ring_level),
      .req_ring_room     (req_if.ring_room),
      .req_packet_ok     (req_if.packet_ok),
      .req_packet_actual (req_if.packet_actual),
      .ctrl              (ctrl),
      .stat              (stat),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_packet_bytes  (rsp_if.packet_bytes),
      .rsp_pop_bytes     (rsp_if.pop_bytes),
      .rsp_silence_bytes (rsp_if.silence_bytes),
      .rsp_push_bytes    (rsp_if.push_bytes),
      .rsp_packet_count  (rsp_if.packet_count),
      .rsp_byte_count    (rsp_if.byte_count),
      .rsp_dropped_count (rsp_if.dropped_count),
      .rsp_starved_count (rsp_if.starved_count),
      .rsp_error_count   (rsp_if.error_count),
      .rsp_empty_count   (rsp_if.empty_count)
   );

endmodule

### rtl/iap_ctrl.sv
// ----------------------------------------------------------------------------
// iap_ctrl
// Sequencer of the packet pacer: walks one command through the steps its route
// needs of divide, multiply, clamp, frame rounding and counter update, then hands it to the output stage.
// ----------------------------------------------------------------------------
module iap_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  iap_pkg::status_type  stat,
   output iap_pkg::ctrl_type    ctrl
);

   iap_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iap_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iap_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (stat.route_paced) begin
                  state_in = iap_pkg::ST_DIV;
               end else if (stat.route_play) begin
                  state_in = iap_pkg::ST_TAKE;
               end else begin
                  state_in = iap_pkg::ST_UPD;
               end
            end
         end
         iap_pkg::ST_DIV:   state_in = iap_pkg::ST_MUL;
         iap_pkg::ST_MUL:   state_in = iap_pkg::ST_CLAMP;
         iap_pkg::ST_CLAMP: state_in = iap_pkg::ST_TAKE;
         iap_pkg::ST_TAKE: begin
            state_in = stat.frame_nz ? iap_pkg::ST_MOD : iap_pkg::ST_TRIM;
         end
         iap_pkg::ST_MOD: begin
            if (stat.step_last) begin
               state_in = iap_pkg::ST_TRIM;
            end
         end
         iap_pkg::ST_TRIM:  state_in = iap_pkg::ST_UPD;
         iap_pkg::ST_UPD:   state_in = iap_pkg::ST_DONE;
         iap_pkg::ST_DONE: begin
            if (stat.out_free) begin
               state_in = iap_pkg::ST_IDLE;
            end
         end
         default:           state_in = iap_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         iap_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctrl.accept = req_valid;
         end
         iap_pkg::ST_DIV:   ctrl.recip    = 1'b1;
         iap_pkg::ST_MUL:   ctrl.mul      = 1'b1;
         iap_pkg::ST_CLAMP: ctrl.clamp    = 1'b1;
         iap_pkg::ST_TAKE:  ctrl.take     = 1'b1;
         iap_pkg::ST_MOD:   ctrl.step     = 1'b1;
         iap_pkg::ST_TRIM:  ctrl.trim     = 1'b1;
         iap_pkg::ST_UPD:   ctrl.upd      = 1'b1;
         iap_pkg::ST_DONE:  ctrl.out_load = stat.out_free;
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

### rtl/iap_dpath.sv
// ----------------------------------------------------------------------------
// iap_dpath
// Datapath of the packet pacer: configuration registers, a reciprocal
// multiply for frames per interval, a shift-subtract unit for frame
// rounding, the frame multiplier, the statistics counters and the output
// register.
// ----------------------------------------------------------------------------
module iap_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [iap_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iap_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_command,
   input  logic [iap_pkg::RING_W-1:0]        req_ring_level,
   input  logic [iap_pkg::RING_W-1:0]        req_ring_room,
   input  logic                              req_packet_ok,
   input  logic [iap_pkg::BYTES_W-1:0]       req_packet_actual,
   input  iap_pkg::ctrl_type                 ctrl,
   output iap_pkg::status_type               stat,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [iap_pkg::BYTES_W-1:0]       rsp_packet_bytes,
   output logic [iap_pkg::BYTES_W-1:0]       rsp_pop_bytes,
   output logic [iap_pkg::BYTES_W-1:0]       rsp_silence_bytes,
   output logic [iap_pkg::BYTES_W-1:0]       rsp_push_bytes,
   output logic [iap_pkg::COUNT_W-1:0]       rsp_packet_count,
   output logic [iap_pkg::COUNT_W-1:0]       rsp_byte_count,
   output logic [iap_pkg::COUNT_W-1:0]       rsp_dropped_count,
   output logic [iap_pkg::COUNT_W-1:0]       rsp_starved_count,
   output logic [iap_pkg::COUNT_W-1:0]       rsp_error_count,
   output logic [iap_pkg::COUNT_W-1:0]       rsp_empty_count
);

   localparam int unsigned BW = iap_pkg::BYTES_W;
   localparam int unsigned CW = iap_pkg::COUNT_W;

   // configuration
   logic                          direction_in_ff;
   logic [iap_pkg::RATE_W-1:0]    sample_rate_ff;
   logic [iap_pkg::FRAME_W-1:0]   frame_bytes_ff;
   logic [iap_pkg::MPS_W-1:0]     max_packet_ff;

   // latched command
   logic                          cmd_ff, cmd_in;
   logic [iap_pkg::RING_W-1:0]    level_ff, level_in;
   logic [iap_pkg::RING_W-1:0]    room_ff, room_in;
   logic                          ok_ff, ok_in;
   logic [BW-1:0]                 actual_ff, actual_in;

   // shift-subtract unit
   logic [iap_pkg::REM_W-1:0]     rdiv_ff, rdiv_in;
   logic [iap_pkg::QUO_W-1:0]     ddiv_ff, ddiv_in;
   logic [iap_pkg::REM_W-1:0]     vdiv_ff, vdiv_in;
   logic [iap_pkg::STEP_W-1:0]    cnt_ff, cnt_in;

   // packet sizing
   logic [iap_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [iap_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [BW-1:0]                 want_ff, want_in;
   logic [BW-1:0]                 take_ff, take_in;
   logic [BW-1:0]                 pop_ff, pop_in;
   logic [BW-1:0]                 sil_ff, sil_in;
   logic [BW-1:0]                 push_ff, push_in;
   logic                          starve_ff, starve_in;

   // statistics
   logic [CW-1:0] packets_ff, packets_in;
   logic [CW-1:0] bytes_ff, bytes_in;
   logic [CW-1:0] drops_ff, drops_in;
   logic [CW-1:0] starves_ff, starves_in;
   logic [CW-1:0] errors_ff, errors_in;
   logic [CW-1:0] empties_ff, empties_in;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [BW-1:0] out_pkt_ff, out_pop_ff, out_sil_ff, out_push_ff;
   logic [CW-1:0] out_packets_ff, out_bytes_ff, out_drops_ff;
   logic [CW-1:0] out_starves_ff, out_errors_ff, out_empties_ff;

   // combinational helpers
   logic [iap_pkg::ACC_W-1:0]        acc;
   logic [iap_pkg::RECIP_PROD_W-1:0] recip_prod;
   logic [iap_pkg::MPS_W-1:0]        mps;
   logic [iap_pkg::REM_W:0]          trial;
   logic [iap_pkg::REM_W:0]          trial_diff;
   logic                             trial_ge;
   logic [BW-1:0]                    take_val;
   logic [BW-1:0]                    pop_val;
   logic                             route_play;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_in_ff <= 1'b0;
         sample_rate_ff  <= '0;
         frame_bytes_ff  <= '0;
         max_packet_ff   <= iap_pkg::MPS_W'(iap_pkg::MAX_PACKET_BYTES);
      end else if (csr_write_en) begin
         case (csr_index)
            iap_pkg::CSR_DIRECTION_IN: direction_in_ff <= csr_write_data[0];
            iap_pkg::CSR_SAMPLE_RATE:  sample_rate_ff  <= csr_write_data[iap_pkg::RATE_W-1:0];
            iap_pkg::CSR_FRAME_BYTES:  frame_bytes_ff  <= csr_write_data[iap_pkg::FRAME_W-1:0];
            iap_pkg::CSR_MAX_PACKET:   max_packet_ff   <= csr_write_data[iap_pkg::MPS_W-1:0];
            default: begin
               direction_in_ff <= direction_in_ff;
            end
         endcase
      end
   end

   always_comb begin
      acc        = iap_pkg::ACC_W'(rem_ff) + iap_pkg::ACC_W'(sample_rate_ff);
      recip_prod = iap_pkg::RECIP_PROD_W'(acc)
                   * iap_pkg::RECIP_PROD_W'(iap_pkg::RECIP_MUL);
      if (max_packet_ff == '0) begin
         mps = iap_pkg::MPS_W'(1);
      end else if (max_packet_ff > iap_pkg::MPS_W'(iap_pkg::MAX_PACKET_BYTES)) begin
         mps = iap_pkg::MPS_W'(iap_pkg::MAX_PACKET_BYTES);
      end else begin
         mps = max_packet_ff;
      end
      trial      = {rdiv_ff, ddiv_ff[iap_pkg::QUO_W-1]};
      trial_diff = trial - {1'b0, vdiv_ff};
      trial_ge   = trial >= {1'b0, vdiv_ff};
      take_val   = (level_ff < iap_pkg::RING_W'(want_ff)) ? level_ff[BW-1:0] : want_ff;
      // remainder never exceeds the rounded amount, so it fits the byte width
      pop_val    = take_ff - rdiv_ff[BW-1:0];
      route_play = (req_command == iap_pkg::CMD_PREPARE) && !direction_in_ff;
   end

   always_comb begin
      stat.route_play  = route_play;
      stat.route_paced = route_play && (frame_bytes_ff != '0) && (sample_rate_ff != '0);
      stat.frame_nz    = frame_bytes_ff != '0;
      stat.step_last   = cnt_ff == iap_pkg::STEP_W'(1);
      stat.out_free    = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      cmd_in     = cmd_ff;
      level_in   = level_ff;
      room_in    = room_ff;
      ok_in      = ok_ff;
      actual_in  = actual_ff;
      rdiv_in    = rdiv_ff;
      ddiv_in    = ddiv_ff;
      vdiv_in    = vdiv_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      prod_in    = prod_ff;
      want_in    = want_ff;
      take_in    = take_ff;
      pop_in     = pop_ff;
      sil_in     = sil_ff;
      push_in    = push_ff;
      starve_in  = starve_ff;
      packets_in = packets_ff;
      bytes_in   = bytes_ff;
      drops_in   = drops_ff;
      starves_in = starves_ff;
      errors_in  = errors_ff;
      empties_in = empties_ff;

      if (ctrl.accept) begin
         cmd_in    = req_command;
         level_in  = req_ring_level;
         room_in   = req_ring_room;
         ok_in     = req_packet_ok;
         actual_in = req_packet_actual;
         want_in   = (req_command == iap_pkg::CMD_PREPARE) ? BW'(mps) : '0;
         pop_in    = '0;
         sil_in    = '0;
         push_in   = '0;
         starve_in = 1'b0;
      end

      // frames per interval
      if (ctrl.recip) begin
         ddiv_in = recip_prod[iap_pkg::RECIP_SHIFT +: iap_pkg::QUO_W];
      end

      if (ctrl.step) begin
         rdiv_in = trial_ge ? trial_diff[iap_pkg::REM_W-1:0] : trial[iap_pkg::REM_W-1:0];
         ddiv_in = {ddiv_ff[iap_pkg::QUO_W-2:0], trial_ge};
         cnt_in  = cnt_ff - iap_pkg::STEP_W'(1);
      end

      if (ctrl.mul) begin
         prod_in = iap_pkg::PROD_W'(ddiv_ff) * iap_pkg::PROD_W'(frame_bytes_ff);
         rem_in  = iap_pkg::REM_W'(acc - iap_pkg::ACC_W'(ddiv_ff)
                                         * iap_pkg::ACC_W'(iap_pkg::MS_PER_SECOND));
      end

      if (ctrl.clamp) begin
         want_in = (prod_ff > iap_pkg::PROD_W'(mps)) ? BW'(mps) : prod_ff[BW-1:0];
      end

      if (ctrl.take) begin
         take_in = take_val;
         rdiv_in = '0;
         ddiv_in = {take_val, (iap_pkg::QUO_W - BW)'(0)};
         vdiv_in = frame_bytes_ff;
         cnt_in  = iap_pkg::MOD_STEPS;
      end

      if (ctrl.trim) begin
         pop_in    = pop_val;
         sil_in    = want_ff - pop_val;
         starve_in = pop_val < want_ff;
      end

      if (ctrl.upd) begin
         if (cmd_ff == iap_pkg::CMD_PREPARE) begin
            if (starve_ff) begin
               starves_in = starves_ff + CW'(1);
            end
         end else if (direction_in_ff) begin
            if (ok_ff && (actual_ff != '0)) begin
               push_in    = (iap_pkg::RING_W'(actual_ff) < room_ff) ? actual_ff
                                                                    : room_ff[BW-1:0];
               if (room_ff < iap_pkg::RING_W'(actual_ff)) begin
                  drops_in = drops_ff + CW'(1);
               end
               bytes_in   = bytes_ff + CW'(actual_ff);
               packets_in = packets_ff + CW'(1);
            end else if (!ok_ff) begin
               errors_in = errors_ff + CW'(1);
            end else begin
               empties_in = empties_ff + CW'(1);
            end
         end else begin
            if (ok_ff) begin
               bytes_in   = bytes_ff + CW'(actual_ff);
               packets_in = packets_ff + CW'(1);
            end else begin
               errors_in = errors_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      level_ff  <= level_in;
      room_ff   <= room_in;
      ok_ff     <= ok_in;
      actual_ff <= actual_in;
      rdiv_ff   <= rdiv_in;
      ddiv_ff   <= ddiv_in;
      vdiv_ff   <= vdiv_in;
      prod_ff   <= prod_in;
      want_ff   <= want_in;
      take_ff   <= take_in;
      pop_ff    <= pop_in;
      sil_ff    <= sil_in;
      push_ff   <= push_in;
      starve_ff <= starve_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rem_ff     <= '0;
         packets_ff <= '0;
         bytes_ff   <= '0;
         drops_ff   <= '0;
         starves_ff <= '0;
         errors_ff  <= '0;
         empties_ff <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
         packets_ff <= packets_in;
         bytes_ff   <= bytes_in;
         drops_ff   <= drops_in;
         starves_ff <= starves_in;
         errors_ff  <= errors_in;
         empties_ff <= empties_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctrl.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         out_pkt_ff     <= want_ff;
         out_pop_ff     <= pop_ff;
         out_sil_ff     <= sil_ff;
         out_push_ff    <= push_ff;
         out_packets_ff <= packets_ff;
         out_bytes_ff   <= bytes_ff;
         out_drops_ff   <= drops_ff;
         out_starves_ff <= starves_ff;
         out_errors_ff  <= errors_ff;
         out_empties_ff <= empties_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_packet_bytes  = out_pkt_ff;
   assign rsp_pop_bytes     = out_pop_ff;
   assign rsp_silence_bytes = out_sil_ff;
   assign rsp_push_bytes    = out_push_ff;
   assign rsp_packet_count  = out_packets_ff;
   assign rsp_byte_count    = out_bytes_ff;
   assign rsp_dropped_count = out_drops_ff;
   assign rsp_starved_count = out_starves_ff;
   assign rsp_error_count   = out_errors_ff;
   assign rsp_empty_count   = out_empties_ff;

endmodule

### rtl/iap_checker.sv
// ----------------------------------------------------------------------------
// iap_checker
// Port-level checks of the packet pacer, bound to the top level.
// ----------------------------------------------------------------------------
module iap_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [iap_pkg::BYTES_W-1:0]    rsp_packet_bytes,
   input logic [iap_pkg::BYTES_W-1:0]    rsp_pop_bytes,
   input logic [iap_pkg::BYTES_W-1:0]    rsp_silence_bytes,
   input logic [iap_pkg::BYTES_W-1:0]    rsp_push_bytes,
   input logic [iap_pkg::COUNT_W-1:0]    rsp_packet_count
);

   // one command in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packet_count))
      else $error("stalled result beat changed");

   // playback fills the packet with ring data plus silence; capture has neither
   a_packet_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_pop_bytes} + {1'b0, rsp_silence_bytes})
                     == {1'b0, rsp_packet_bytes})
                    || (rsp_pop_bytes == '0 && rsp_silence_bytes == '0))
      else $error("pop and silence do not add up to the packet length");

   a_push_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_bytes != '0 |-> rsp_packet_bytes == '0
                                           && rsp_pop_bytes == '0
                                           && rsp_silence_bytes == '0)
      else $error("capture push on a prepare result");

endmodule

bind iso_audio_packet_pacer iap_checker u_iap_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_packet_bytes  (rsp_if.packet_bytes),
   .rsp_pop_bytes     (rsp_if.pop_bytes),
   .rsp_silence_bytes (rsp_if.silence_bytes),
   .rsp_push_bytes    (rsp_if.push_bytes),
   .rsp_packet_count  (rsp_if.packet_count)
);

### tb/iap_packet_checker.sv
// ----------------------------------------------------------------------------
// iap_packet_checker
// Watches the command, result and register ports of the packet pacer. Keeps
// its own copy of the registers, the rate remainder and the six counters,
// computes the result of every accepted command beat and compares each
// result beat, field by field, with the oldest one still expected.
// ----------------------------------------------------------------------------
module iap_packet_checker (
   input  logic                           clock,
   input  logic                           reset,
   iap_req_if                             req_mon,
   iap_rsp_if                             rsp_mon,
   input  logic                           csr_write_en,
   input  logic [iap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [iap_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int unsigned                    open_reports,
   output int unsigned                    mismatches
);

   localparam logic [iap_pkg::RING_W-1:0] RING_MAX =
      iap_pkg::RING_W'(iap_pkg::RING_BYTES_MAX);

   typedef struct packed {
      logic [iap_pkg::BYTES_W-1:0] packet_bytes;
      logic [iap_pkg::BYTES_W-1:0] pop_bytes;
      logic [iap_pkg::BYTES_W-1:0] silence_bytes;
      logic [iap_pkg::BYTES_W-1:0] push_bytes;
      logic [iap_pkg::COUNT_W-1:0] packet_count;
      logic [iap_pkg::COUNT_W-1:0] byte_count;
      logic [iap_pkg::COUNT_W-1:0] dropped_count;
      logic [iap_pkg::COUNT_W-1:0] starved_count;
      logic [iap_pkg::COUNT_W-1:0] error_count;
      logic [iap_pkg::COUNT_W-1:0] empty_count;
   } report_type;

   // register copy
   logic                        capture_dir;
   logic [iap_pkg::RATE_W-1:0]  rate;
   logic [iap_pkg::FRAME_W-1:0] frame_size;
   logic [iap_pkg::MPS_W-1:0]   mps_reg;

   // pacing and statistics state
   logic [iap_pkg::REM_W-1:0]   remainder;
   logic [iap_pkg::COUNT_W-1:0] packets, bytes_sum, drops, starves, errors, empties;

   report_type  expected_reports[$];
   int unsigned fail_tally = 0;

   function automatic string show(report_type r);
      return $sformatf({"pkt=%0d pop=%0d sil=%0d push=%0d pkts=%0d bytes=%0d ",
                        "drop=%0d starve=%0d err=%0d empty=%0d"},
                       r.packet_bytes, r.pop_bytes, r.silence_bytes, r.push_bytes,
                       r.packet_count, r.byte_count, r.dropped_count, r.starved_count,
                       r.error_count, r.empty_count);
   endfunction

   task automatic pace_and_account(input logic cmd,
                                   input logic [iap_pkg::RING_W-1:0] level_in,
                                   input logic [iap_pkg::RING_W-1:0] room_in,
                                   input logic ok,
                                   input logic [iap_pkg::BYTES_W-1:0] actual,
                                   output report_type r);
      logic [iap_pkg::RING_W-1:0]  level, room;
      logic [iap_pkg::MPS_W-1:0]   mps;
      logic [iap_pkg::ACC_W-1:0]   acc;
      logic [iap_pkg::QUO_W-1:0]   frames;
      logic [iap_pkg::PROD_W-1:0]  paced;
      logic [iap_pkg::BYTES_W-1:0] want, take;
      level = (level_in > RING_MAX) ? RING_MAX : level_in;
      room  = (room_in > RING_MAX) ? RING_MAX : room_in;
      if (mps_reg == '0)
         mps = iap_pkg::MPS_W'(1);
      else if (mps_reg > iap_pkg::MAX_PACKET_BYTES)
         mps = iap_pkg::MPS_W'(iap_pkg::MAX_PACKET_BYTES);
      else
         mps = mps_reg;
      r = '0;
      if (cmd == iap_pkg::CMD_PREPARE) begin
         want = mps;
         if (!capture_dir && frame_size != '0 && rate != '0) begin
            acc       = iap_pkg::ACC_W'(remainder) + iap_pkg::ACC_W'(rate);
            frames    = iap_pkg::QUO_W'(acc / iap_pkg::MS_PER_SECOND);
            remainder = iap_pkg::REM_W'(acc - iap_pkg::ACC_W'(frames)
                                              * iap_pkg::MS_PER_SECOND);
            paced     = iap_pkg::PROD_W'(frames) * iap_pkg::PROD_W'(frame_size);
            want      = (paced > mps) ? mps : iap_pkg::BYTES_W'(paced);
         end
         if (!capture_dir) begin
            take = (level < want) ? iap_pkg::BYTES_W'(level) : want;
            // whole frames only
            if (frame_size != '0) take = take - iap_pkg::BYTES_W'(take % frame_size);
            r.pop_bytes = take;
            if (take < want) begin
               r.silence_bytes = want - take;
               starves++;
            end
         end
         r.packet_bytes = want;
      end else if (capture_dir) begin
         if (ok && actual != '0) begin
            r.push_bytes = (actual < room) ? actual : iap_pkg::BYTES_W'(room);
            if (r.push_bytes < actual) drops++;
            bytes_sum += iap_pkg::COUNT_W'(actual);
            packets++;
         end else if (!ok) begin
            errors++;
         end else begin
            empties++;
         end
      end else begin
         // playback: a zero-byte completion still counts as data
         if (ok) begin
            bytes_sum += iap_pkg::COUNT_W'(actual);
            packets++;
         end else begin
            errors++;
         end
      end
      r.packet_count  = packets;
      r.byte_count    = bytes_sum;
      r.dropped_count = drops;
      r.starved_count = starves;
      r.error_count   = errors;
      r.empty_count   = empties;
   endtask

   always @(posedge clock) begin
      report_type want_r, got_r;
      if (reset) begin
         capture_dir = 1'b0;
         rate        = '0;
         frame_size  = '0;
         mps_reg     = iap_pkg::MPS_W'(iap_pkg::MAX_PACKET_BYTES);
         remainder   = '0;
         packets     = '0;
         bytes_sum   = '0;
         drops       = '0;
         starves     = '0;
         errors      = '0;
         empties     = '0;
         expected_reports.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               iap_pkg::CSR_DIRECTION_IN: capture_dir = csr_write_data[0];
               iap_pkg::CSR_SAMPLE_RATE:  rate        = csr_write_data[iap_pkg::RATE_W-1:0];
               iap_pkg::CSR_FRAME_BYTES:  frame_size  = csr_write_data[iap_pkg::FRAME_W-1:0];
               iap_pkg::CSR_MAX_PACKET:   mps_reg     = csr_write_data[iap_pkg::MPS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_r = {rsp_mon.packet_bytes, rsp_mon.pop_bytes, rsp_mon.silence_bytes,
                     rsp_mon.push_bytes, rsp_mon.packet_count, rsp_mon.byte_count,
                     rsp_mon.dropped_count, rsp_mon.starved_count, rsp_mon.error_count,
                     rsp_mon.empty_count};
            if (expected_reports.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("unexpected result beat: %s", show(got_r));
            end else begin
               want_r = expected_reports.pop_front();
               if (got_r !== want_r) begin
                  fail_tally++;
                  if (fail_tally <= 10) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  expected %s", show(want_r));
                     $display("  actual   %s", show(got_r));
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pace_and_account(req_mon.command, req_mon.ring_level, req_mon.ring_room,
                             req_mon.packet_ok, req_mon.packet_actual, want_r);
            expected_reports.push_back(want_r);
         end
      end
      open_reports <= expected_reports.size();
      mismatches   <= fail_tally;
   end

endmodule

### tb/tb_iso_audio_packet_pacer.sv
// ----------------------------------------------------------------------------
// tb_iso_audio_packet_pacer
// Drives the packet pacer with a directed set of prepare and complete
// commands over extreme register settings, then randomized phases of
// commands, each phase under a fresh register setting. Both channels idle at
// random. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_iso_audio_packet_pacer;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned RANDOM_PHASES = 16;
   localparam int unsigned PHASE_ITEMS   = 50;
   localparam logic [iap_pkg::RING_W-1:0] RING_FULL =
      iap_pkg::RING_W'(iap_pkg::RING_BYTES_MAX);
   localparam logic [iap_pkg::RING_W-1:0] RING_ALL1 = '1;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_en;
   logic [iap_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [iap_pkg::CSR_DATA_W-1:0] csr_write_data;
   int unsigned                    open_reports;
   int unsigned                    mismatches;
   int unsigned                    cycle_count = 0;
   bit                             no_idle = 1'b0;

   iap_req_if req_bus();
   iap_rsp_if rsp_bus();

   iso_audio_packet_pacer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   iap_packet_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .open_reports   (open_reports),
      .mismatches     (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[iso_audio_packet_pacer] ERROR");
         $finish;
      end
   end

   function automatic int unsigned idle_gap();
      return no_idle ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic logic [iap_pkg::RING_W-1:0] pick_ring();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return iap_pkg::RING_W'($urandom_range(0, 300));
         2:       return RING_FULL;
         3:       return iap_pkg::RING_W'($urandom);
         4:       return iap_pkg::RING_W'($urandom_range(0, iap_pkg::RING_BYTES_MAX));
         default: return RING_ALL1;
      endcase
   endfunction

   // result side: stall a random number of cycles before every beat
   initial begin
      int unsigned n;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         n = idle_gap();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   task automatic send_cmd(input logic cmd, input logic [iap_pkg::RING_W-1:0] level,
                           input logic [iap_pkg::RING_W-1:0] room, input logic ok,
                           input logic [iap_pkg::BYTES_W-1:0] actual);
      int unsigned n;
      n = idle_gap();
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= cmd;
      req_bus.ring_level    <= level;
      req_bus.ring_room     <= room;
      req_bus.packet_ok     <= ok;
      req_bus.packet_actual <= actual;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // wait for every outstanding result, then let the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (open_reports != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic apply_config(input logic dir, input logic [iap_pkg::RATE_W-1:0] rate,
                               input logic [iap_pkg::FRAME_W-1:0] fsize,
                               input logic [iap_pkg::MPS_W-1:0] mps);
      csr_write_en   <= 1'b1;
      csr_index      <= iap_pkg::CSR_DIRECTION_IN;
      csr_write_data <= iap_pkg::CSR_DATA_W'(dir);
      @(posedge clock);
      csr_index      <= iap_pkg::CSR_SAMPLE_RATE;
      csr_write_data <= rate;
      @(posedge clock);
      csr_index      <= iap_pkg::CSR_FRAME_BYTES;
      csr_write_data <= iap_pkg::CSR_DATA_W'(fsize);
      @(posedge clock);
      csr_index      <= iap_pkg::CSR_MAX_PACKET;
      csr_write_data <= iap_pkg::CSR_DATA_W'(mps);
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      logic [iap_pkg::RATE_W-1:0]  rate;
      logic [iap_pkg::FRAME_W-1:0] fsize;
      logic [iap_pkg::MPS_W-1:0]   mps;
      logic [iap_pkg::BYTES_W-1:0] actual;
      logic                        dir;
      reset                 <= 1'b1;
      csr_write_en          <= 1'b0;
      csr_index             <= iap_pkg::CSR_DIRECTION_IN;
      csr_write_data        <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.command       <= iap_pkg::CMD_PREPARE;
      req_bus.ring_level    <= '0;
      req_bus.ring_room     <= '0;
      req_bus.packet_ok     <= 1'b0;
      req_bus.packet_actual <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: unpaced playback, full-size packets
      send_cmd(iap_pkg::CMD_PREPARE,  '0,        RING_ALL1, 1'b1, iap_pkg::BYTES_W'(256));
      send_cmd(iap_pkg::CMD_PREPARE,  RING_ALL1, '0,        1'b0, '0);
      send_cmd(iap_pkg::CMD_PREPARE,  iap_pkg::RING_W'(100), RING_FULL, 1'b1,
               iap_pkg::BYTES_W'(17));
      send_cmd(iap_pkg::CMD_COMPLETE, '0,        '0,        1'b1, iap_pkg::BYTES_W'(256));
      send_cmd(iap_pkg::CMD_COMPLETE, RING_ALL1, RING_ALL1, 1'b1, '0);
      send_cmd(iap_pkg::CMD_COMPLETE, '0,        '0,        1'b0, iap_pkg::BYTES_W'(99));
      drain();

      apply_config(1'b0, iap_pkg::RATE_W'(48000), iap_pkg::FRAME_W'(4),
                   iap_pkg::MPS_W'(256));
      send_cmd(iap_pkg::CMD_PREPARE,  RING_ALL1,            '0, 1'b0, '0);
      send_cmd(iap_pkg::CMD_PREPARE,  iap_pkg::RING_W'(10), '0, 1'b0, '0);
      send_cmd(iap_pkg::CMD_COMPLETE, '0,                   '0, 1'b1,
               iap_pkg::BYTES_W'(192));
      drain();

      // fractional rate, packet clamped and then rounded below the clamp
      apply_config(1'b0, iap_pkg::RATE_W'(44100), iap_pkg::FRAME_W'(6),
                   iap_pkg::MPS_W'(200));
      send_cmd(iap_pkg::CMD_PREPARE, RING_ALL1, '0, 1'b1, '0);
      send_cmd(iap_pkg::CMD_PREPARE, RING_ALL1, '0, 1'b1, '0);
      send_cmd(iap_pkg::CMD_PREPARE, '0,        '0, 1'b1, '0);
      drain();

      // zero frames per interval; max packet of zero
      apply_config(1'b0, iap_pkg::RATE_W'(1), iap_pkg::FRAME_W'(3), iap_pkg::MPS_W'(0));
      send_cmd(iap_pkg::CMD_PREPARE, iap_pkg::RING_W'(5), '0, 1'b0, '0);
      drain();

      apply_config(1'b0, '1, '1, '1);
      send_cmd(iap_pkg::CMD_PREPARE, iap_pkg::RING_W'(1000), '0, 1'b0, '0);
      drain();

      // unpaced, rounded to whole frames
      apply_config(1'b0, '0, iap_pkg::FRAME_W'(5), iap_pkg::MPS_W'(100));
      send_cmd(iap_pkg::CMD_PREPARE, iap_pkg::RING_W'(57), '0, 1'b0, '0);
      drain();

      apply_config(1'b1, '1, '1, '1);
      send_cmd(iap_pkg::CMD_PREPARE,  iap_pkg::RING_W'(3), iap_pkg::RING_W'(3), 1'b1,
               iap_pkg::BYTES_W'(256));
      send_cmd(iap_pkg::CMD_COMPLETE, '0, iap_pkg::RING_W'(100), 1'b1,
               iap_pkg::BYTES_W'(256));
      send_cmd(iap_pkg::CMD_COMPLETE, '0,        RING_ALL1, 1'b1, iap_pkg::BYTES_W'(256));
      send_cmd(iap_pkg::CMD_COMPLETE, '0,        RING_ALL1, 1'b1, '0);
      send_cmd(iap_pkg::CMD_COMPLETE, '0,        RING_ALL1, 1'b0, iap_pkg::BYTES_W'(50));
      send_cmd(iap_pkg::CMD_COMPLETE, RING_ALL1, '0,        1'b1, iap_pkg::BYTES_W'(1));
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         dir = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 4))
            0: rate = '0;
            1: rate = iap_pkg::RATE_W'($urandom_range(1, 999));
            2: begin
               case ($urandom_range(0, 7))
                  0: rate = iap_pkg::RATE_W'(8000);
                  1: rate = iap_pkg::RATE_W'(16000);
                  2: rate = iap_pkg::RATE_W'(22050);
                  3: rate = iap_pkg::RATE_W'(32000);
                  4: rate = iap_pkg::RATE_W'(44100);
                  5: rate = iap_pkg::RATE_W'(88200);
                  6: rate = iap_pkg::RATE_W'(96000);
                  default: rate = iap_pkg::RATE_W'(48000);
               endcase
            end
            3: rate = iap_pkg::RATE_W'($urandom);
            default: rate = '1;
         endcase
         case ($urandom_range(0, 5))
            0:       fsize = '0;
            1:       fsize = '1;
            2:       fsize = iap_pkg::FRAME_W'($urandom);
            default: fsize = iap_pkg::FRAME_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 7))
            0:       mps = '0;
            1:       mps = iap_pkg::MPS_W'($urandom_range(257, 511));
            2:       mps = iap_pkg::MPS_W'(256);
            default: mps = iap_pkg::MPS_W'($urandom_range(1, 256));
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         apply_config(dir, rate, fsize, mps);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 4))
               0:       actual = '0;
               1:       actual = iap_pkg::BYTES_W'(256);
               default: actual = iap_pkg::BYTES_W'($urandom_range(0, 256));
            endcase
            send_cmd($urandom_range(0, 1) ? iap_pkg::CMD_COMPLETE : iap_pkg::CMD_PREPARE,
                     pick_ring(), pick_ring(), ($urandom_range(0, 7) != 0), actual);
         end
         drain();
      end

      if (mismatches == 0)
         $display("[iso_audio_packet_pacer] OK");
      else
         $display("[iso_audio_packet_pacer] ERROR");
      $finish;
   end

endmodule
